[hdl/mlrq_pkg.sv]
`default_nettype none
package mlrq_pkg;
	localparam int NUM_TASKS_DEF = 16;
	localparam int NUM_LEVELS_DEF = 3;

	typedef enum logic [1:0] {
		FUNC_ENQ = 2'd0,
		FUNC_REM = 2'd1,
		FUNC_ROT = 2'd2,
		FUNC_GET = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_BADLV = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item
		logic start_walk; // load cur from head
		logic step;      // advance cur/prev
		logic do_enq;
		logic do_rem;    // unlink cur
		logic do_rot;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad_level;
		logic task_bad;
		logic lvl_empty;
		logic rot_ok;
		logic cur_ok;    // cur is a valid task number
		logic cur_hit;   // cur equals the task
		logic walk_done; // step limit reached
	} dp_sts_t;
endpackage
`default_nettype wire

[hdl/multilevel_ready_queue_unit.sv]
// Multilevel ready queue: one linked FIFO of tasks per priority level.
// Enqueue, rotate, get-next and rejected items pass from accept through the
// decode state, the pending stage and the result register; remove walks the
// level list, one link per cycle, for at most NUM_TASKS steps. The controller
// takes one item at a time and accepts the next only when back in idle;
// a decode waits while a held result waits on m_tready.
// Reset (arst_n low, asynchronous): all levels empty, every link at end mark.
`default_nettype none
module multilevel_ready_queue_unit
	import mlrq_pkg::*;
#(
	parameter int NUM_TASKS = NUM_TASKS_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // func[1:0], task_id[5:2], level[7:6]
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata   // best_task[3:0], best_valid[4], status[6:5], 0
);
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic ready, res_load, in_fire, out_free;
	status_t res_status;
	logic [3:0] best_task;
	logic best_valid;
	logic [6:0] res_q;
	logic ov_q;

	assign s_tready = ready;
	assign in_fire = s_tvalid && ready;
	// output register is free when empty or being drained
	assign out_free = !ov_q || m_tready;

	mlrq_ctrl u_ctrl (
		.clk, .arst_n, .in_fire,
		.func(func_t'(s_tdata[1:0])),
		.sts, .out_free, .cmd, .ready, .res_load, .res_status
	);

	mlrq_dp #(.NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS)) u_dp (
		.clk, .arst_n, .cmd,
		.task_in(s_tdata[5:2]), .level_in(s_tdata[7:6]),
		.sts, .best_task, .best_valid
	);

	// result register; the list update commanded with res_load is in place
	// the cycle after, so res_load is delayed through pend_q before best is sampled
	logic pend_q;
	status_t pst_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			pend_q <= 1'b0;
			pst_q <= ST_DONE;
			res_q <= '0;
		end else begin
			if (ov_q && m_tready) ov_q <= 1'b0;
			pend_q <= res_load;
			if (res_load) pst_q <= res_status;
			if (pend_q) begin
				res_q <= {pst_q, best_valid, best_task};
				ov_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata = {1'b0, res_q};
endmodule
`default_nettype wire

[hdl/mlrq_ctrl.sv]
`default_nettype none
module mlrq_ctrl
	import mlrq_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_fire,
	input  wire func_t   func,
	input  wire dp_sts_t sts,
	input  wire logic    out_free,
	output dp_cmd_t      cmd,
	output logic         ready,
	output logic         res_load,
	output status_t      res_status
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DEC  = 4'b0010,
		S_WALK = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_n;
	func_t  func_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q <= FUNC_GET;
		end else begin
			state_q <= state_n;
			if (in_fire) func_q <= func;
		end
	end

	always_comb begin
		state_n = state_q;
		cmd = '0;
		res_load = 1'b0;
		res_status = ST_DONE;
		ready = (state_q == S_IDLE);
		cmd.load = in_fire;
		unique case (state_q)
			S_IDLE: if (in_fire) state_n = S_DEC;
			S_DEC: begin
				if (out_free) begin
					state_n = S_IDLE;
					res_load = 1'b1;
					if (func_q == FUNC_GET) res_status = ST_DONE;
					else if (sts.bad_level) res_status = ST_BADLV;
					else if (func_q == FUNC_ROT) begin
						res_status = sts.rot_ok ? ST_DONE : ST_MISS;
						cmd.do_rot = sts.rot_ok;
					end else if (sts.task_bad) res_status = ST_MISS;
					else if (func_q == FUNC_ENQ) cmd.do_enq = 1'b1;
					else if (sts.lvl_empty) res_status = ST_MISS;
					else begin
						res_load = 1'b0;
						cmd.start_walk = 1'b1;
						state_n = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (!sts.cur_ok || sts.walk_done) state_n = S_OUT;
				else if (sts.cur_hit) begin
					cmd.do_rem = 1'b1;
					state_n = S_OUT;
				end else cmd.step = 1'b1;
			end
			S_OUT: begin
				// hit status comes from cur_q, which do_rem leaves unchanged
				res_load = 1'b1;
				res_status = sts.cur_hit && sts.cur_ok && !sts.walk_done ?
					ST_DONE : ST_MISS;
				state_n = S_IDLE;
			end
			default: state_n = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[hdl/mlrq_dp.sv]
`default_nettype none
module mlrq_dp
	import mlrq_pkg::*;
#(
	parameter int NUM_TASKS = NUM_TASKS_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	input  wire logic [3:0] task_in,
	input  wire logic [1:0] level_in,
	output dp_sts_t         sts,
	output logic [3:0]      best_task,
	output logic            best_valid
);
	localparam int TW = $clog2(NUM_TASKS);
	localparam int LW = TW + 1;
	localparam int LVW = $clog2(NUM_LEVELS);
	localparam logic [LW-1:0] END_MARK = LW'(NUM_TASKS);

	logic [TW-1:0] head_q [NUM_LEVELS];
	logic [TW-1:0] tail_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] ne_q;
	logic [LW-1:0] link_q [NUM_TASKS];

	logic [3:0] task_q;
	logic [1:0] lvin_q;
	logic [LW-1:0] cur_q, prev_q;
	logic [LW-1:0] steps_q;

	logic [LVW-1:0] lv;
	logic lv_ok, t_ok;
	logic [LW-1:0] tfull;
	logic [LW-1:0] nxt;
	logic [TW-1:0] hd, tl, cur_t, prev_t;

	assign lv_ok = (lvin_q != 2'd0) && ({30'd0, lvin_q} <= 32'(NUM_LEVELS));
	assign lv = lv_ok ? LVW'(lvin_q - 2'd1) : '0;
	assign tfull = LW'(task_q);
	assign t_ok = tfull < END_MARK;
	assign hd = head_q[lv];
	assign tl = tail_q[lv];
	assign cur_t = cur_q[TW-1:0];
	assign prev_t = prev_q[TW-1:0];
	assign nxt = link_q[cur_t];

	logic [LW-1:0] fnext;
	assign fnext = link_q[hd];

	always_comb begin
		sts.bad_level = !lv_ok;
		sts.task_bad = !t_ok;
		sts.lvl_empty = !ne_q[lv];
		sts.rot_ok = ne_q[lv] && (hd != tl) && (fnext < END_MARK);
		sts.cur_ok = cur_q < END_MARK;
		sts.cur_hit = cur_q == tfull;
		sts.walk_done = steps_q >= END_MARK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			for (int i = 0; i < NUM_TASKS; i++) link_q[i] <= END_MARK;
			cur_q <= END_MARK;
			prev_q <= END_MARK;
			steps_q <= '0;
			task_q <= '0;
			lvin_q <= '0;
		end else begin
			if (cmd.load) begin
				task_q <= task_in;
				lvin_q <= level_in;
			end
			if (cmd.start_walk) begin
				cur_q <= {1'b0, hd};
				prev_q <= END_MARK;
				steps_q <= '0;
			end
			if (cmd.step) begin
				prev_q <= cur_q;
				cur_q <= nxt;
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.do_enq) begin
				// appending the tail task again links it to itself
				link_q[task_q[TW-1:0]] <= (ne_q[lv] && tl == task_q[TW-1:0]) ?
					tfull : END_MARK;
				tail_q[lv] <= task_q[TW-1:0];
				if (!ne_q[lv]) begin
					head_q[lv] <= task_q[TW-1:0];
					ne_q[lv] <= 1'b1;
				end else if (tl != task_q[TW-1:0]) begin
					link_q[tl] <= tfull;
				end
			end
			if (cmd.do_rot) begin
				head_q[lv] <= fnext[TW-1:0];
				link_q[tl] <= {1'b0, hd};
				tail_q[lv] <= hd;
				link_q[hd] <= END_MARK;
			end
			if (cmd.do_rem) begin
				link_q[cur_t] <= END_MARK;
				if (prev_q == END_MARK) begin
					if (!(nxt < END_MARK) || cur_t == tl) begin
						ne_q[lv] <= 1'b0;
						head_q[lv] <= '0;
						tail_q[lv] <= '0;
					end else head_q[lv] <= nxt[TW-1:0];
				end else begin
					if (prev_t != cur_t) link_q[prev_t] <= nxt;
					if (cur_t == tl) tail_q[lv] <= prev_t;
				end
			end
		end
	end

	always_comb begin
		best_task = '0;
		best_valid = 1'b0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (ne_q[i]) begin
				best_task = 4'(head_q[i]);
				best_valid = 1'b1;
			end
		end
	end
endmodule
`default_nettype wire
